/* hdl/csrf_pkg.sv */
// ----------------------------------------------------------------------------
// Cave smoothing row filter package
// Shared types and constants for the row filter, its lanes and its queue.
// ----------------------------------------------------------------------------
package csrf_pkg;

  // Width of the grid_width configuration register and its reset value.
  localparam int unsigned CfgW        = 7;
  localparam logic [CfgW-1:0] GridWidthRst = 7'd64;

  // Wall count at which a cell keeps its previous value.
  localparam logic [3:0] RulePivot = 4'd4;

  // Number of result slots in the output queue.
  localparam int unsigned QueueDepth = 4;

  // 3x3 neighborhood of one column; bit 0 is the left column, bit 2 the right.
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] mid;
    logic [2:0] below;
  } nbhd_t;

  // Push request to the output queue; second is only set together with first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

/* hdl/cave_smoothing_row_filter_unit.sv */
// A result enters the output queue when the row that causes it is transferred.
// Throughput: one row per cycle while the queue has room, one result per cycle while
// not stalled; a final row after held rows puts two results into the four-slot queue.
// Reset: asynchronous, active low; clears held rows and the queue, width returns to 64.
// ----------------------------------------------------------------------------
// Cave smoothing row filter
// One pass of the 4-5 cave smoothing rule over a grid taken one row at a time.
// Two banks of column lanes smooth the held row and, on the final row, the
// final row itself; the queue merges their results into the output stream.
// ----------------------------------------------------------------------------
module cave_smoothing_row_filter_unit #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [csrf_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [MAX_WIDTH-1:0]      row_cells_i,
  input  logic                      last_row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [MAX_WIDTH-1:0]      smoothed_row_o,
  output logic                      frame_end_o
);

  localparam logic [csrf_pkg::CfgW-1:0] MaxW = csrf_pkg::CfgW'(MAX_WIDTH);

  logic [csrf_pkg::CfgW-1:0] grid_width_q, eff_w;
  logic [MAX_WIDTH-1:0]      upper_q, upper_d, middle_q, middle_d;
  logic [1:0]                held_q, held_d;
  logic [MAX_WIDTH-1:0]      col_en, ones;
  logic [MAX_WIDTH-1:0]      above_a, mid_a, below_a, res_a, res_b;
  logic [MAX_WIDTH+1:0]      ext_above_a, ext_mid_a, ext_below_a;
  logic [MAX_WIDTH+1:0]      ext_above_b, ext_mid_b, ext_below_b;
  logic                      accept, room, first_row;
  csrf_pkg::push_t           push;

  assign ones       = '1;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = ~room;
  assign first_row  = held_q == 2'd0;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= csrf_pkg::GridWidthRst;
    end else if (cfg_we_i) begin
      grid_width_q <= cfg_wdata_i;
    end
  end

  assign eff_w = (grid_width_q > MaxW) ? MaxW : grid_width_q;

  // Operands of bank A: the held row, or the sole row of a one-row grid.
  assign above_a = first_row ? ones        : upper_q;
  assign mid_a   = first_row ? row_cells_i : middle_q;
  assign below_a = first_row ? ones        : row_cells_i;

  // Pad each row with walls on both sides and past the used width.
  assign ext_above_a = {1'b1, above_a | ~col_en, 1'b1};
  assign ext_mid_a   = {1'b1, mid_a | ~col_en, 1'b1};
  assign ext_below_a = {1'b1, below_a | ~col_en, 1'b1};
  assign ext_above_b = {1'b1, middle_q | ~col_en, 1'b1};
  assign ext_mid_b   = {1'b1, row_cells_i | ~col_en, 1'b1};
  assign ext_below_b = {1'b1, ones, 1'b1};

  // Column lanes: bank A and bank B, one lane per column each.
  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_col
    csrf_pkg::nbhd_t nb_a, nb_b;

    assign col_en[x] = csrf_pkg::CfgW'(x) < eff_w;

    assign nb_a.above = ext_above_a[x+2:x];
    assign nb_a.mid   = ext_mid_a[x+2:x];
    assign nb_a.below = ext_below_a[x+2:x];
    assign nb_b.above = ext_above_b[x+2:x];
    assign nb_b.mid   = ext_mid_b[x+2:x];
    assign nb_b.below = ext_below_b[x+2:x];

    csrf_lane u_lane_a (
      .en_i   (col_en[x]),
      .nbhd_i (nb_a),
      .cell_o (res_a[x])
    );

    csrf_lane u_lane_b (
      .en_i   (col_en[x]),
      .nbhd_i (nb_b),
      .cell_o (res_b[x])
    );
  end

  // Row window update and push requests.
  always_comb begin
    upper_d     = upper_q;
    middle_d    = middle_q;
    held_d      = held_q;
    push.first  = 1'b0;
    push.second = 1'b0;
    if (accept) begin
      if (last_row_i) begin
        push.first  = 1'b1;
        push.second = ~first_row;
        upper_d     = '0;
        middle_d    = '0;
        held_d      = 2'd0;
      end else begin
        push.first = ~first_row;
        upper_d    = first_row ? ones : middle_q;
        middle_d   = row_cells_i;
        held_d     = first_row ? 2'd1 : 2'd2;
      end
    end
  end

  // Row window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      held_q   <= 2'd0;
    end else begin
      upper_q  <= upper_d;
      middle_q <= middle_d;
      held_q   <= held_d;
    end
  end

  // Bank A ends the frame only for a one-row grid.
  csrf_queue #(
    .DATA_W (MAX_WIDTH + 1)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i ({first_row & last_row_i, res_a}),
    .data_b_i ({1'b1, res_b}),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .data_o   ({frame_end_o, smoothed_row_o})
  );

endmodule

/* hdl/csrf_lane.sv */
// ----------------------------------------------------------------------------
// Cave smoothing lane
// Counts the walls around one cell and applies the 4-5 rule.
// ----------------------------------------------------------------------------
module csrf_lane (
  input  logic            en_i,
  input  csrf_pkg::nbhd_t nbhd_i,
  output logic            cell_o
);

  logic [3:0] walls;

  // Sum of the eight neighbors; the center cell is left out.
  assign walls = {3'b0, nbhd_i.above[0]} + {3'b0, nbhd_i.above[1]} +
                 {3'b0, nbhd_i.above[2]} + {3'b0, nbhd_i.mid[0]} +
                 {3'b0, nbhd_i.mid[2]}   + {3'b0, nbhd_i.below[0]} +
                 {3'b0, nbhd_i.below[1]} + {3'b0, nbhd_i.below[2]};

  // Above the pivot is wall, at the pivot the cell keeps its value.
  assign cell_o = en_i & ((walls > csrf_pkg::RulePivot) ||
                          ((walls == csrf_pkg::RulePivot) && nbhd_i.mid[1]));

endmodule

/* hdl/csrf_queue.sv */
// ----------------------------------------------------------------------------
// Cave smoothing result queue
// Merges the results of both lane banks into one stream of output transfers.
// ----------------------------------------------------------------------------
module csrf_queue #(
  parameter int unsigned DATA_W = 65
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csrf_pkg::push_t   push_i,
  input  logic [DATA_W-1:0] data_a_i,
  input  logic [DATA_W-1:0] data_b_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(csrf_pkg::QueueDepth);

  logic [DATA_W-1:0] mem_q [csrf_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d, n_push;
  logic [PtrW-1:0]   wr_next;
  logic              pop;

  // Number of results pushed this cycle.
  always_comb begin
    unique case ({push_i.first, push_i.second})
      2'b11:   n_push = (PtrW+1)'(2);
      2'b10:   n_push = (PtrW+1)'(1);
      default: n_push = '0;
    endcase
  end

  assign pop      = valid_o & ~stall_i;
  assign wr_next  = wr_ptr_q + PtrW'(1);
  assign wr_ptr_d = wr_ptr_q + n_push[PtrW-1:0];
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + n_push - (PtrW+1)'(pop);

  // Room for two results keeps a final row from overflowing the queue.
  assign room_o  = count_q <= (PtrW+1)'(csrf_pkg::QueueDepth - 2);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= data_b_i;
    end
  end

endmodule

/* hdl/csrf_checker.sv */
// ----------------------------------------------------------------------------
// Cave smoothing row filter checker
// Port-level assertions on the row filter, attached by bind.
// ----------------------------------------------------------------------------
module csrf_checker #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      last_row_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [MAX_WIDTH-1:0]      smoothed_row_o,
  input logic                      frame_end_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(smoothed_row_o) && $stable(frame_end_o))
    else $error("result changed while stalled");

  // Reset empties the result queue, so nothing is offered as reset ends.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  // After the transfer of a final row, a result is always offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_row_i |=> out_valid_o)
    else $error("final row transfer produced no result");

endmodule

bind cave_smoothing_row_filter_unit csrf_checker #(.MAX_WIDTH(MAX_WIDTH)) u_csrf_checker (.*);

/* tb/tb_cave_smoothing_row_filter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cave smoothing row filter testbench
// Feeds grids of random and hand-picked rows through the row filter and
// checks every smoothed row against a local model of the 4-5 rule. Grid width
// settings and idle patterns on both channels change from phase to phase.
// ----------------------------------------------------------------------------
module tb_cave_smoothing_row_filter_unit;

  localparam int unsigned GridMax    = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseRows  = 120;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned DrainWait  = 4;
  localparam logic [GridMax-1:0] AllWalls = {GridMax{1'b1}};

  // How many rows the model holds while waiting for the row below.
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_TOP   = 2'd1,
    HOLD_INNER = 2'd2
  } hold_e;

  typedef struct packed {
    logic [GridMax-1:0] cells;
    logic               frame_end;
  } smoothed_t;

  // A hand-picked row; when fixed is set its results must all equal want.
  typedef struct packed {
    logic [GridMax-1:0] cells;
    logic               last;
    logic               fixed;
    logic [GridMax-1:0] want;
  } row_case_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [csrf_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [GridMax-1:0]        row_cells_i = '0;
  logic                      last_row_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [GridMax-1:0]        smoothed_row_o;
  logic                      frame_end_o;

  // Fixed expectation that travels with the row payload.
  logic               fixed_i = 1'b0;
  logic [GridMax-1:0] want_i = '0;

  int                 send_idle = 32;
  int                 recv_stall = 69;
  int                 errors = 0;
  int unsigned        cycles = 0;

  // Model state.
  logic [GridMax-1:0]        row_above;
  logic [GridMax-1:0]        row_held;
  hold_e                     held;
  logic [csrf_pkg::CfgW-1:0] grid_cols;
  smoothed_t                 smoothed_q[$];

  row_case_t hand_rows [17] = '{
    '{64'h0, 1'b1, 1'b1, AllWalls},
    '{AllWalls, 1'b1, 1'b1, AllWalls},
    '{AllWalls, 1'b0, 1'b1, AllWalls},
    '{AllWalls, 1'b0, 1'b1, AllWalls},
    '{AllWalls, 1'b1, 1'b1, AllWalls},
    '{64'h0, 1'b0, 1'b0, 64'h0},
    '{64'h0, 1'b0, 1'b0, 64'h0},
    '{64'h0, 1'b1, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
    '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 64'h0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0},
    '{64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
    '{64'h0000_0001_0000_0000, 1'b0, 1'b0, 64'h0},
    '{64'h0000_0003_8000_0000, 1'b0, 1'b0, 64'h0},
    '{64'h0000_0001_0000_0000, 1'b1, 1'b0, 64'h0}
  };

  logic [csrf_pkg::CfgW-1:0] phase_cols [NumPhases] = '{
    7'd10, 7'd64, 7'd0, 7'd1, 7'd9, 7'd127, 7'd65, 7'd37, 7'd63, 7'd2, 7'd11, 7'd10
  };

  cave_smoothing_row_filter_unit #(
    .MAX_WIDTH(GridMax)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_cells_i    (row_cells_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_row_o (smoothed_row_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Out-of-grid neighbors count as walls.
  function automatic int wall_at(input logic [GridMax-1:0] cells, input int x, input int cols);
    if (x < 0 || x >= cols) return 1;
    return int'(cells[x]);
  endfunction

  // One pass of the 4-5 rule over the middle row at the current width.
  function automatic logic [GridMax-1:0] smooth_cells(input logic [GridMax-1:0] above,
                                                      input logic [GridMax-1:0] mid,
                                                      input logic [GridMax-1:0] below);
    int                 cols;
    int                 walls;
    logic [GridMax-1:0] res;
    cols = (int'(grid_cols) > GridMax) ? GridMax : int'(grid_cols);
    res = '0;
    for (int x = 0; x < cols; x++) begin
      walls = 0;
      for (int dx = -1; dx <= 1; dx++) begin
        walls += wall_at(above, x + dx, cols) + wall_at(below, x + dx, cols);
        if (dx != 0) walls += wall_at(mid, x + dx, cols);
      end
      if (walls > int'(csrf_pkg::RulePivot) ||
          (walls == int'(csrf_pkg::RulePivot) && mid[x])) res[x] = 1'b1;
    end
    return res;
  endfunction

  task automatic expect_smoothed(input logic [GridMax-1:0] cells, input logic fend,
                                 input logic fixed, input logic [GridMax-1:0] want);
    smoothed_t s;
    s.cells = fixed ? want : cells;
    s.frame_end = fend;
    smoothed_q.push_back(s);
  endtask

  // Advances the model by one accepted row and queues the rows it releases.
  task automatic take_row(input logic [GridMax-1:0] cells, input logic last,
                          input logic fixed, input logic [GridMax-1:0] want);
    if (held == HOLD_NONE) begin
      if (last) begin
        expect_smoothed(smooth_cells(AllWalls, cells, AllWalls), 1'b1, fixed, want);
        row_above = '0;
        row_held = '0;
      end else begin
        row_above = AllWalls;
        row_held = cells;
        held = HOLD_TOP;
      end
    end else begin
      expect_smoothed(smooth_cells(row_above, row_held, cells), 1'b0, fixed, want);
      if (last) begin
        expect_smoothed(smooth_cells(row_held, cells, AllWalls), 1'b1, fixed, want);
        row_above = '0;
        row_held = '0;
        held = HOLD_NONE;
      end else begin
        row_above = row_held;
        row_held = cells;
        held = HOLD_INNER;
      end
    end
  endtask

  // Checks results first, then predicts from the row taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above = '0;
      row_held = '0;
      held = HOLD_NONE;
      grid_cols = csrf_pkg::GridWidthRst;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (smoothed_q.size() == 0) begin
          $error("unexpected result: smoothed_row %h frame_end %b", smoothed_row_o, frame_end_o);
          errors++;
        end else begin
          if (smoothed_row_o !== smoothed_q[0].cells) begin
            $error("smoothed_row: expected %h, got %h", smoothed_q[0].cells, smoothed_row_o);
            errors++;
          end
          if (frame_end_o !== smoothed_q[0].frame_end) begin
            $error("frame_end: expected %b, got %b", smoothed_q[0].frame_end, frame_end_o);
            errors++;
          end
          void'(smoothed_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) take_row(row_cells_i, last_row_i, fixed_i, want_i);
      if (cfg_we_i) grid_cols = cfg_wdata_i;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one row after a random gap and waits for its transfer.
  task automatic send_row(input logic [GridMax-1:0] cells, input logic last,
                          input logic fixed, input logic [GridMax-1:0] want);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_cells_i <= cells;
    last_row_i <= last;
    fixed_i <= fixed;
    want_i <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until every expected row has come out and the block is quiet.
  // It first lets the model take the last accepted row.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Mix of dense, sparse, balanced and uniform rows.
  function automatic logic [GridMax-1:0] random_cells();
    logic [GridMax-1:0] a;
    logic [GridMax-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return a & b;
      1:       return a | b;
      2:       return '0;
      3:       return AllWalls;
      4:       return AllWalls ^ (64'h1 << $urandom_range(63));
      default: return a;
    endcase
  endfunction

  initial begin
    int rows_left;
    rows_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked grids at the reset width.
    foreach (hand_rows[i]) begin
      send_row(hand_rows[i].cells, hand_rows[i].last, hand_rows[i].fixed, hand_rows[i].want);
    end
    drain();

    // Random grids; phase ends may fall inside a grid, so width changes hit held rows.
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 4)
        0: begin send_idle = 32; recv_stall = 69; end
        1: begin send_idle = 69; recv_stall = 32; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= (p == NumPhases - 2) ? 7'($urandom_range(127)) : phase_cols[p];
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < PhaseRows; n++) begin
        if (rows_left == 0) begin
          rows_left = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 16);
        end
        send_row(random_cells(), rows_left == 1, 1'b0, '0);
        rows_left--;
      end
      drain();
    end

    if (errors == 0 && smoothed_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
